// ===== hdl/plsf_pkg.sv =====
// Shared types, constants and helper functions of the Potts spin-flip core.
`timescale 1ns / 1ps
package plsf_pkg;

  // Lattice geometry and spin width.
  localparam int LATTICE_ROWS = 64;
  localparam int LATTICE_COLS = 64;
  localparam int SPIN_BITS    = 8;

  // Fixed field widths of the channels.
  localparam int SITE_W     = 6;
  localparam int SITE_RANGE = 1 << SITE_W;
  localparam int CMD_W      = 2;
  localparam int VAL_W      = 8;
  localparam int NSV_W      = 9;
  localparam int CNT_W      = 4;
  localparam int CMP_W      = 16;

  // Derived memory geometry.
  localparam int ROW_W     = $clog2(LATTICE_ROWS);
  localparam int COL_W     = $clog2(LATTICE_COLS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // Command codes; the unused code behaves as a read.
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLIP = 2'd2;

  // Reset value of the spin count register.
  localparam logic [NSV_W-1:0] NSV_RESET = 9'd2;

  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [SPIN_BITS-1:0] spin_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef row_t row_tbl_t [SITE_RANGE];
  typedef col_t col_tbl_t [SITE_RANGE];

  // Wrap tables for the coordinate fields, built at elaboration.
  function automatic row_tbl_t build_row_tbl();
    row_tbl_t t;
    for (int i = 0; i < SITE_RANGE; i++) begin
      t[i] = ROW_W'(i % LATTICE_ROWS);
    end
    return t;
  endfunction

  function automatic col_tbl_t build_col_tbl();
    col_tbl_t t;
    for (int i = 0; i < SITE_RANGE; i++) begin
      t[i] = COL_W'(i % LATTICE_COLS);
    end
    return t;
  endfunction

  localparam row_tbl_t ROW_WRAP = build_row_tbl();
  localparam col_tbl_t COL_WRAP = build_col_tbl();

  // A spin is valid when it is below the spin count and fits the stored width.
  function automatic logic spin_ok(logic [VAL_W-1:0] s, logic [NSV_W-1:0] nsv);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(s);
    return (NSV_W'(s) < nsv) && ((wide >> SPIN_BITS) == '0);
  endfunction

  // Low byte of a stored spin, as the result field shows it.
  function automatic logic [VAL_W-1:0] spin_byte(spin_t v);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(v);
    return wide[VAL_W-1:0];
  endfunction

endpackage

// ===== hdl/plsf_if.sv =====
// Request, result and configuration channel interfaces of the spin-flip core.
`timescale 1ns / 1ps

interface plsf_in_if
  import plsf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SITE_W-1:0] site_x;
  logic [SITE_W-1:0] site_y;
  logic [VAL_W-1:0]  spin_value;

  modport source (output valid, cmd, site_x, site_y, spin_value, input ready);
  modport sink   (input valid, cmd, site_x, site_y, spin_value, output ready);
endinterface

interface plsf_out_if
  import plsf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] site_spin;
  logic             flip_accepted;
  logic [CNT_W-1:0] old_matches;
  logic [CNT_W-1:0] new_matches;
  logic             bad_candidate;

  modport source (output valid, site_spin, flip_accepted, old_matches, new_matches,
                  bad_candidate, input ready);
  modport sink   (input valid, site_spin, flip_accepted, old_matches, new_matches,
                  bad_candidate, output ready);
endinterface

interface plsf_cfg_if
  import plsf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [NSV_W-1:0] num_spin_values;

  modport source (output valid, num_spin_values, input ready);
  modport sink   (input valid, num_spin_values, output ready);
endinterface

// ===== hdl/potts_lattice_spin_flip_core.sv =====
// Top level of the zero-temperature Potts spin-flip core with its lattice memory.
//
// The core keeps a periodic lattice of spins in one synchronous memory and serves
// one request at a time from in_req: load a spin, read a spin, or attempt a flip.
// Each request yields exactly one result on out_rsp (valid/ready handshake).
// cfg_wr writes the spin count register at any time; it is always ready.
// Load and read perform one center read and a write-back slot. A flip uses the
// single memory read port to fetch the center and the eight neighbors one per
// cycle, followed by the write-back. The result appears in the output register
// in the cycle after the write-back slot.
// The output register lets the next request enter while a result waits; a
// request that finishes while the previous result is still untaken holds in its
// write-back slot until the receiver takes it.
// After reset the core clears all MEM_DEPTH entries of the lattice (4096 at a
// 64 by 64 lattice), one entry per cycle; no request is taken meanwhile.
`timescale 1ns / 1ps
module potts_lattice_spin_flip_core
  import plsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  plsf_in_if.sink    in_req,
  plsf_out_if.source out_rsp,
  plsf_cfg_if.sink   cfg_wr
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_READ   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  // Read steps: the center first, then the eight neighbors.
  localparam cnt_t STEP_CENTER = 4'd0;
  localparam cnt_t STEP_UL     = 4'd1;
  localparam cnt_t STEP_UC     = 4'd2;
  localparam cnt_t STEP_UR     = 4'd3;
  localparam cnt_t STEP_ML     = 4'd4;
  localparam cnt_t STEP_MR     = 4'd5;
  localparam cnt_t STEP_DL     = 4'd6;
  localparam cnt_t STEP_DC     = 4'd7;
  localparam cnt_t STEP_DR     = 4'd8;
  localparam cnt_t STEP_LAST   = 4'd9;
  localparam cnt_t MAX_MATCHES = 4'd8;

  state_t state_r, state_nxt;

  logic [NSV_W-1:0] nsv_r;

  // Request registers.
  logic [CMD_W-1:0] cmd_r;
  logic [VAL_W-1:0] spin_r;
  logic             ok_r;
  row_t             row_r, up_r, dn_r;
  col_t             col_r, lf_r, rt_r;

  // Sequencer and accumulation registers.
  cnt_t  step_r, step_nxt;
  addr_t clr_cnt_r;
  spin_t old_r;
  cnt_t  old_cnt_r, new_cnt_r;

  // Memory ports.
  spin_t lattice_mem [MEM_DEPTH];
  spin_t rd_data_r;
  addr_t rd_addr;
  addr_t wr_addr;
  spin_t wr_data;
  logic  mem_we;

  // Output register.
  logic             out_valid_r;
  logic [VAL_W-1:0] out_spin_r;
  logic             out_acc_r;
  cnt_t             out_old_r, out_new_r;
  logic             out_bad_r;

  logic in_fire;
  logic is_flip, is_load, flip_live;
  logic out_free, finish_go, accepted, store_en;
  row_t in_row;
  col_t in_col;

  assign in_fire   = in_req.valid && in_req.ready;
  assign is_flip   = (cmd_r == CMD_FLIP);
  assign is_load   = (cmd_r == CMD_LOAD);
  assign flip_live = is_flip && ok_r;
  assign out_free  = !out_valid_r || out_rsp.ready;
  assign finish_go = (state_r == ST_FINISH) && out_free;
  assign accepted  = flip_live && (old_cnt_r <= new_cnt_r);
  assign store_en  = (is_load && ok_r) || accepted;
  assign in_row    = ROW_WRAP[in_req.site_x];
  assign in_col    = COL_WRAP[in_req.site_y];

  assign in_req.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready = 1'b1;

  // Spin count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nsv_r <= NSV_RESET;
    end else if (cfg_wr.valid) begin
      nsv_r <= cfg_wr.num_spin_values;
    end
  end

  // Capture the request and its wrapped neighbor coordinates.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_req.cmd;
      spin_r <= in_req.spin_value;
      ok_r   <= spin_ok(in_req.spin_value, nsv_r);
      row_r  <= in_row;
      col_r  <= in_col;
      up_r   <= (in_row == '0) ? row_t'(LATTICE_ROWS - 1) : in_row - row_t'(1);
      dn_r   <= (in_row == row_t'(LATTICE_ROWS - 1)) ? '0 : in_row + row_t'(1);
      lf_r   <= (in_col == '0) ? col_t'(LATTICE_COLS - 1) : in_col - col_t'(1);
      rt_r   <= (in_col == col_t'(LATTICE_COLS - 1)) ? '0 : in_col + col_t'(1);
    end
  end

  // Read address for the current step.
  always_comb begin
    case (step_r)
      STEP_UL: rd_addr = {up_r, lf_r};
      STEP_UC: rd_addr = {up_r, col_r};
      STEP_UR: rd_addr = {up_r, rt_r};
      STEP_ML: rd_addr = {row_r, lf_r};
      STEP_MR: rd_addr = {row_r, rt_r};
      STEP_DL: rd_addr = {dn_r, lf_r};
      STEP_DC: rd_addr = {dn_r, col_r};
      STEP_DR: rd_addr = {dn_r, rt_r};
      default: rd_addr = {row_r, col_r};
    endcase
  end

  // Write port: the clearing pass or the write-back of a request.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else begin
      mem_we  = finish_go && store_en;
      wr_addr = {row_r, col_r};
      wr_data = spin_t'(spin_r);
    end
  end

  // Lattice memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lattice_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= lattice_mem[rd_addr];
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == addr_t'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        step_nxt = STEP_CENTER;
        if (in_fire) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        step_nxt = step_r + cnt_t'(1);
        if ((step_r == STEP_UL && !flip_live) || step_r == STEP_LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      step_r    <= STEP_CENTER;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + addr_t'(1);
      end
    end
  end

  // Center capture and neighbor match counting, one memory word per cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      old_cnt_r <= '0;
      new_cnt_r <= '0;
    end else if (state_r == ST_READ) begin
      if (step_r == STEP_UL) begin
        old_r <= rd_data_r;
      end else if (step_r != STEP_CENTER && flip_live) begin
        if (rd_data_r == old_r) begin
          old_cnt_r <= old_cnt_r + cnt_t'(1);
        end
        if (CMP_W'(rd_data_r) == CMP_W'(spin_r)) begin
          new_cnt_r <= new_cnt_r + cnt_t'(1);
        end
      end
    end
  end

  // Output register and its handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_go) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_spin_r <= store_en ? spin_r : spin_byte(old_r);
      out_acc_r  <= accepted;
      out_old_r  <= old_cnt_r;
      out_new_r  <= new_cnt_r;
      out_bad_r  <= (is_load || is_flip) && !ok_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.site_spin     = out_spin_r;
  assign out_rsp.flip_accepted = out_acc_r;
  assign out_rsp.old_matches   = out_old_r;
  assign out_rsp.new_matches   = out_new_r;
  assign out_rsp.bad_candidate = out_bad_r;

  // Checks on the sequencer and the counters.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_FINISH) |->
      (old_cnt_r <= MAX_MATCHES && new_cnt_r <= MAX_MATCHES))
    else $error("neighbor match count exceeds eight");

  a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_FINISH))
    else $error("lattice write outside the clear pass or write-back slot");

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_READ && step_r == STEP_CENTER))
    else $error("accepted request did not start at the center read");

  a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
    finish_go |=> out_valid_r)
    else $error("finished request did not reach the output register");

endmodule

// ===== sim/potts_lattice_spin_flip_core_tb.sv =====
// Self-checking testbench of the Potts spin-flip core against a lattice shadow predictor.
`timescale 1ns / 1ps
module potts_lattice_spin_flip_core_tb;
  import plsf_pkg::*;

  // The unused command code, which the core serves as a read.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int SITE_COUNT = LATTICE_ROWS * LATTICE_COLS;
  // Cycles without any handshake before the run is abandoned; covers the clearing pass.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [VAL_W-1:0] site_spin;
    logic             flip_accepted;
    cnt_t             old_matches;
    cnt_t             new_matches;
    logic             bad_candidate;
  } spin_result_t;

  logic clk;
  logic rst_n;

  plsf_in_if  in_req();
  plsf_out_if out_rsp();
  plsf_cfg_if cfg_wr();

  potts_lattice_spin_flip_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  // Shadow copy of the lattice and the spin count register.
  spin_t            lattice_shadow [SITE_COUNT];
  logic [NSV_W-1:0] spin_count_shadow;
  spin_result_t     expected_results [$];

  bit steady_flow;
  int mismatch_count;
  int requests_sent;
  int results_checked;
  int flips_accepted;
  int flips_rejected;
  int invalid_spins;
  int idle_cycles;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Prints one line per mismatch up to a cap and counts all of them.
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t: result %0d: %s is %0d, expected %0d", $time, results_checked, what, got,
               want);
    end
  endtask

  function automatic bit spin_valid(input int v);
    return (v < int'(spin_count_shadow)) && (v < (1 << SPIN_BITS));
  endfunction

  // Counts the eight periodic neighbors of a site that hold the given spin.
  function automatic int count_neighbors(input int r, input int c, input spin_t s);
    int n;
    int nr;
    int nc;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) begin
          nr = (r + dr + LATTICE_ROWS) % LATTICE_ROWS;
          nc = (c + dc + LATTICE_COLS) % LATTICE_COLS;
          if (lattice_shadow[nr * LATTICE_COLS + nc] == s) n++;
        end
      end
    end
    return n;
  endfunction

  // Applies one request to the shadow lattice and returns the result it must produce.
  function automatic spin_result_t predict_outcome(input logic [CMD_W-1:0] op, input int x,
                                                   input int y, input int v);
    spin_result_t res;
    int r;
    int c;
    int idx;
    int nold;
    int nnew;
    r = x % LATTICE_ROWS;
    c = y % LATTICE_COLS;
    idx = r * LATTICE_COLS + c;
    res = '0;
    if (op == CMD_LOAD) begin
      if (spin_valid(v)) begin
        lattice_shadow[idx] = spin_t'(v);
      end else begin
        res.bad_candidate = 1'b1;
        invalid_spins++;
      end
    end else if (op == CMD_FLIP) begin
      if (spin_valid(v)) begin
        nold = count_neighbors(r, c, lattice_shadow[idx]);
        nnew = count_neighbors(r, c, spin_t'(v));
        res.old_matches = cnt_t'(nold);
        res.new_matches = cnt_t'(nnew);
        if (nold <= nnew) begin
          lattice_shadow[idx] = spin_t'(v);
          res.flip_accepted = 1'b1;
          flips_accepted++;
        end else begin
          flips_rejected++;
        end
      end else begin
        res.bad_candidate = 1'b1;
        invalid_spins++;
      end
    end
    res.site_spin = VAL_W'(lattice_shadow[idx]);
    return res;
  endfunction

  // Sends one request after a random gap; called and returning at a falling edge.
  task automatic send_request(input logic [CMD_W-1:0] op, input int x, input int y,
                              input int v);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.cmd        = op;
    in_req.site_x     = SITE_W'(x);
    in_req.site_y     = SITE_W'(y);
    in_req.spin_value = VAL_W'(v);
    in_req.valid      = 1'b1;
    do @(posedge clk); while (!in_req.ready);
    expected_results.push_back(predict_outcome(op, x, y, v));
    requests_sent++;
    @(negedge clk);
  endtask

  // Holds off new requests until every outstanding result has come back.
  task automatic wait_idle();
    in_req.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Writes the spin count register while the core is idle.
  task automatic write_spin_count(input int n);
    wait_idle();
    cfg_wr.num_spin_values = NSV_W'(n);
    cfg_wr.valid = 1'b1;
    do @(posedge clk); while (!cfg_wr.ready);
    spin_count_shadow = NSV_W'(n);
    @(negedge clk);
    cfg_wr.valid = 1'b0;
  endtask

  // The lattice must read back as zero after reset, and flips on a uniform field behave.
  task automatic test_reset_contents();
    send_request(CMD_READ, 0, 0, 0);
    send_request(CMD_READ, 63, 63, 255);
    send_request(CMD_SPARE, 31, 17, 1);
    send_request(CMD_FLIP, 5, 5, 1);
    send_request(CMD_FLIP, 5, 6, 0);
  endtask

  // Spins at and beyond the configured count, including a count of one and of zero.
  task automatic test_spin_count_limits();
    write_spin_count(256);
    send_request(CMD_LOAD, 63, 63, 255);
    send_request(CMD_LOAD, 0, 0, 128);
    send_request(CMD_READ, 63, 63, 0);
    write_spin_count(1);
    send_request(CMD_LOAD, 1, 1, 1);
    send_request(CMD_LOAD, 1, 1, 0);
    send_request(CMD_FLIP, 1, 1, 0);
    write_spin_count(0);
    send_request(CMD_LOAD, 2, 2, 0);
    send_request(CMD_FLIP, 2, 2, 0);
    send_request(CMD_READ, 2, 2, 0);
  endtask

  // Neighbor counts across the lattice corner, with one accepted and one rejected flip.
  task automatic test_periodic_flip();
    write_spin_count(256);
    send_request(CMD_LOAD, 63, 63, 7);
    send_request(CMD_LOAD, 63, 0, 7);
    send_request(CMD_LOAD, 63, 1, 7);
    send_request(CMD_LOAD, 0, 63, 7);
    send_request(CMD_LOAD, 0, 1, 7);
    send_request(CMD_FLIP, 0, 0, 7);
    send_request(CMD_FLIP, 0, 0, 0);
  endtask

  // Random traffic concentrated on a small patch so that neighbor counts vary widely.
  task automatic test_random_phase(input int spin_count, input int items, input bit no_gaps);
    int cx;
    int cy;
    int pick;
    int x;
    int y;
    int v;
    logic [CMD_W-1:0] op;
    write_spin_count(spin_count);
    steady_flow = no_gaps;
    // Some patches sit on the lattice corner to exercise the wrap.
    if ($urandom_range(0, 2) == 0) begin
      cx = 0;
      cy = 0;
    end else begin
      cx = $urandom_range(0, 63);
      cy = $urandom_range(0, 63);
    end
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) op = CMD_LOAD;
      else if (pick < 33) op = CMD_READ;
      else if (pick < 37) op = CMD_SPARE;
      else op = CMD_FLIP;
      if ($urandom_range(0, 3) != 0) begin
        x = (cx + $urandom_range(0, 4) + 62) % 64;
        y = (cy + $urandom_range(0, 4) + 62) % 64;
      end else begin
        x = $urandom_range(0, 63);
        y = $urandom_range(0, 63);
      end
      if (spin_count > 0 && $urandom_range(0, 9) != 0) begin
        v = $urandom_range(0, (spin_count > 256 ? 256 : spin_count) - 1);
      end else begin
        v = $urandom_range(0, 255);
      end
      send_request(op, x, y, v);
    end
    steady_flow = 1'b0;
  endtask

  // Result receiver: a random stall before taking each result.
  initial begin
    int stall;
    out_rsp.ready = 1'b0;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_rsp.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_rsp.ready = 1'b1;
      do @(posedge clk); while (!(rst_n && out_rsp.valid));
      @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    spin_result_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, site_spin", out_rsp.site_spin, -1);
      end else begin
        want = expected_results.pop_front();
        if (out_rsp.site_spin !== want.site_spin)
          report_mismatch("site_spin", out_rsp.site_spin, want.site_spin);
        if (out_rsp.flip_accepted !== want.flip_accepted)
          report_mismatch("flip_accepted", out_rsp.flip_accepted, want.flip_accepted);
        if (out_rsp.old_matches !== want.old_matches)
          report_mismatch("old_matches", out_rsp.old_matches, want.old_matches);
        if (out_rsp.new_matches !== want.new_matches)
          report_mismatch("new_matches", out_rsp.new_matches, want.new_matches);
        if (out_rsp.bad_candidate !== want.bad_candidate)
          report_mismatch("bad_candidate", out_rsp.bad_candidate, want.bad_candidate);
      end
      results_checked++;
    end
  end

  // Watchdog on cycles in which no handshake completes.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst_n                  = 1'b0;
    in_req.valid           = 1'b0;
    in_req.cmd             = CMD_READ;
    in_req.site_x          = '0;
    in_req.site_y          = '0;
    in_req.spin_value      = '0;
    cfg_wr.valid           = 1'b0;
    cfg_wr.num_spin_values = '0;
    steady_flow            = 1'b0;
    mismatch_count         = 0;
    requests_sent          = 0;
    results_checked        = 0;
    flips_accepted         = 0;
    flips_rejected         = 0;
    invalid_spins          = 0;
    idle_cycles            = 0;
    spin_count_shadow      = NSV_RESET;
    foreach (lattice_shadow[i]) lattice_shadow[i] = '0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_reset_contents();
    test_spin_count_limits();
    test_periodic_flip();
    test_random_phase(2, 300, 1'b0);
    test_random_phase(3, 300, 1'b0);
    test_random_phase(256, 300, 1'b1);
    test_random_phase(1, 150, 1'b0);
    test_random_phase(0, 100, 1'b0);
    test_random_phase(5, 350, 1'b0);
    test_random_phase($urandom_range(2, 255), 330, 1'b0);

    // Drain, then give the core time to show any stray result.
    wait_idle();
    repeat (30) @(negedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", 0, expected_results.size());
    end

    $display("Run covered %0d requests and %0d results: %0d flips taken, %0d refused,",
             requests_sent, results_checked, flips_accepted, flips_rejected);
    $display("%0d invalid spins, spin counts from 0 to 256; %0d mismatches.", invalid_spins,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
